### hw/rtl/sts_pkg.sv
// Shared types and constants for the sorted table search block.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int MATCH_W     = 10;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    MODE_BINARY = 1'b0,
    MODE_LINEAR = 1'b1
  } mode_t;

  // Request from the sequencer to the table memory.
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

endpackage

### hw/rtl/sts_table.sv
// Table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sts_table (
  input  logic                             clk,
  input  sts_pkg::mem_req_t                req,
  output logic signed [sts_pkg::DATA_W-1:0] rd_data
);

  logic signed [sts_pkg::DATA_W-1:0] ram [sts_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      ram[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= ram[req.raddr];
    end
  end

endmodule

### hw/rtl/sts_ctrl.sv
// Sequencer: entry count, append writes, binary and linear probe loop, result register.
`timescale 1ns / 1ps

module sts_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic signed [sts_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [sts_pkg::MATCH_W-1:0]       match_index,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  output sts_pkg::mem_req_t                 mem_req,
  input  logic signed [sts_pkg::DATA_W-1:0] rd_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PROBE  = 4'b0010,
    S_CHECK  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                            state, state_next;
  logic [sts_pkg::CNT_W-1:0]         entry_count;
  sts_pkg::mode_t                    search_mode;
  logic signed [sts_pkg::DATA_W-1:0] target;
  logic [sts_pkg::CNT_W-1:0]         lo, hi;   // live range is [lo, hi)
  logic [sts_pkg::IDX_W-1:0]         probe_idx;
  logic                              hit;

  logic                      accept;
  logic                      table_full;
  logic                      range_live;
  logic [sts_pkg::CNT_W-1:0] span;
  logic [sts_pkg::CNT_W-1:0] mid;
  logic [sts_pkg::CNT_W-1:0] probe_addr;
  logic                      out_load;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign table_full = (entry_count == sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH));
  assign range_live = (lo < hi);
  assign span       = hi - lo - sts_pkg::CNT_W'(1);
  assign mid        = lo + (span >> 1);
  assign probe_addr = (search_mode == sts_pkg::MODE_LINEAR) ? lo : mid;
  assign out_load   = (state == S_FINISH) && (!out_valid || out_ready);

  // Writes happen only on an accepted append in idle, reads only while probing,
  // so the two ports never touch the same entry in one cycle.
  always_comb begin
    mem_req.we    = accept && (sts_pkg::func_t'(func) == sts_pkg::FUNC_APPEND)
                    && !table_full;
    mem_req.waddr = entry_count[sts_pkg::IDX_W-1:0];
    mem_req.wdata = value;
    mem_req.re    = (state == S_PROBE) && range_live;
    mem_req.raddr = probe_addr[sts_pkg::IDX_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (sts_pkg::func_t'(func) == sts_pkg::FUNC_SEARCH)) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE:  state_next = range_live ? S_CHECK : S_FINISH;
      S_CHECK:  state_next = (rd_data == target) ? S_FINISH : S_PROBE;
      S_FINISH: state_next = out_load ? S_IDLE : S_FINISH;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      search_mode <= sts_pkg::MODE_BINARY;
      out_valid   <= 1'b0;
      hit         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        search_mode <= sts_pkg::mode_t'(cfg_wdata);
      end
      if (accept) begin
        case (sts_pkg::func_t'(func))
          sts_pkg::FUNC_CLEAR:  entry_count <= '0;
          sts_pkg::FUNC_APPEND: begin
            if (!table_full) begin
              entry_count <= entry_count + sts_pkg::CNT_W'(1);
            end
          end
          sts_pkg::FUNC_SEARCH: hit <= 1'b0;
          default: ;
        endcase
      end
      if (state == S_CHECK && rd_data == target) begin
        hit <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search datapath: range bounds, probe index, result register.
  always_ff @(posedge clk) begin
    if (accept && (sts_pkg::func_t'(func) == sts_pkg::FUNC_SEARCH)) begin
      target <= value;
      lo     <= '0;
      hi     <= entry_count;
    end
    if (state == S_PROBE && range_live) begin
      probe_idx <= probe_addr[sts_pkg::IDX_W-1:0];
    end
    if (state == S_CHECK && rd_data != target) begin
      if (search_mode == sts_pkg::MODE_LINEAR) begin
        lo <= lo + sts_pkg::CNT_W'(1);
      end else if (rd_data < target) begin
        lo <= {1'b0, probe_idx} + sts_pkg::CNT_W'(1);
      end else begin
        hi <= {1'b0, probe_idx};
      end
    end
    if (out_load) begin
      found       <= hit;
      match_index <= hit ? sts_pkg::MATCH_W'(probe_idx) : '0;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH))
    else $error("entry count past table depth");

  a_read_below_count: assert property (@(posedge clk) disable iff (rst)
    mem_req.re |-> ({1'b0, mem_req.raddr} < entry_count))
    else $error("probe beyond filled entries");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == S_IDLE))
    else $error("table write during a search");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_index == '0))
    else $error("miss reported with nonzero index");

  a_check_follows_probe: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(mem_req.re))
    else $error("compare without a memory read");

endmodule

### hw/rtl/sorted_table_search.sv
// Top level of the sorted table search block.
`timescale 1ns / 1ps
// Usage: a table of up to 1024 signed 32-bit entries with a search engine.
// Input channel (in_valid/in_ready) carries func and value:
//   clear resets the fill count (data stays), append writes value at the
//   next free entry (dropped when full), search looks for value.
// Output channel (out_valid/out_ready) carries found and match_index, one
// transfer per search only; a miss reports index 0.
// cfg_we/cfg_wdata set the mode: 0 binary search over an ascending table,
// 1 linear scan from entry 0 for the first match.
// A search does setup, then probes (one synchronous memory read, then a
// compare each), then finish. The single memory read port sets the rate.
// One item is worked at a time; in_ready is high while idle, including
// while an earlier result waits in the output register.
// When the receiver stalls, the result holds and a finished search waits
// until the output register frees up.
// Reset (rst, synchronous) empties the table, selects binary mode and
// drops any pending result; the memory contents are not cleared.

module sorted_table_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic signed [sts_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [sts_pkg::MATCH_W-1:0]       match_index,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata
);

  sts_pkg::mem_req_t                 mem_req;
  logic signed [sts_pkg::DATA_W-1:0] rd_data;

  sts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_index (match_index),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

  sts_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
